// ===== src/csd_pkg.sv =====
// Shared constants and types for the corner set stability detector.
package csd_pkg;

    localparam int CSD_HISTORY_FRAMES = 10;
    localparam int CSD_MAX_CORNERS    = 64;
    localparam int CSD_QUEUE_DEPTH    = 2;
    localparam int CSD_COORD_W        = 16;
    localparam int CSD_ERR_W          = 27;

    localparam logic [CSD_ERR_W-1:0] CSD_THRESH_RESET = 27'd8000;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_FLUSH,
        BK_DONE
    } t_back_state;

endpackage

// ===== src/csd_queue.sv =====
// Small first-in first-out queue between the front and back parts.
module csd_queue #(
    parameter int W     = 40,
    parameter int DEPTH = csd_pkg::CSD_QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_data [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_data[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_data[r_wptr] <= i_data;
        end
    end

endmodule

// ===== src/csd_front.sv =====
// Front part: accepts corners, tracks the position within the frame and queues commands.
module csd_front #(
    parameter int MAX_CORNERS = csd_pkg::CSD_MAX_CORNERS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,
    input  logic         i_s_tlast,
    input  logic         i_full,
    output logic         o_push,
    output logic [2*csd_pkg::CSD_COORD_W+$clog2(MAX_CORNERS)+1:0] o_cmd
);
    localparam int IW = $clog2(MAX_CORNERS);
    localparam int PW = $clog2(MAX_CORNERS + 1);

    logic [PW-1:0] r_pos;
    logic          in_range;

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;
    assign in_range   = (r_pos < PW'(MAX_CORNERS));
    assign o_cmd      = {i_s_tlast, in_range, r_pos[IW-1:0],
                         i_s_tdata[2*csd_pkg::CSD_COORD_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_push) begin
            if (i_s_tlast) begin
                r_pos <= '0;
            end else if (in_range) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

endmodule

// ===== src/csd_back.sv =====
// Back part: compares each corner against the stored frames and reports frame results.
module csd_back #(
    parameter int HISTORY_FRAMES = csd_pkg::CSD_HISTORY_FRAMES,
    parameter int MAX_CORNERS    = csd_pkg::CSD_MAX_CORNERS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cmd_vld,
    input  logic [2*csd_pkg::CSD_COORD_W+$clog2(MAX_CORNERS)+1:0] i_cmd,
    output logic         o_pop,
    input  logic         i_cfg_we,
    input  logic [csd_pkg::CSD_ERR_W-1:0] i_cfg_wdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [31:0]  o_m_tdata
);
    localparam int CW  = csd_pkg::CSD_COORD_W;
    localparam int EW  = csd_pkg::CSD_ERR_W;
    localparam int IW  = $clog2(MAX_CORNERS);
    localparam int SW  = $clog2(HISTORY_FRAMES);
    localparam int FW  = $clog2(HISTORY_FRAMES + 1);
    localparam int AW  = $clog2(HISTORY_FRAMES * MAX_CORNERS);
    localparam int DW  = 2 * CW + IW + 2;
    localparam int MD  = HISTORY_FRAMES * MAX_CORNERS;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    csd_pkg::t_back_state r_state;
    csd_pkg::t_back_state n_state;

    logic [DW-1:0]   r_cmd;
    logic [SW-1:0]   r_step;
    logic [AW-1:0]   r_raddr;
    logic [2*CW-1:0] r_mem [MD];
    logic [2*CW-1:0] r_rdata;
    logic            r_rd_vld;
    logic            r_rd_skip;
    logic [EW-1:0]   r_sum;
    logic [EW-1:0]   r_thresh;
    logic [FW-1:0]   r_nfill;
    logic [SW-1:0]   r_slot;
    logic [AW-1:0]   r_base;
    logic            r_out_vld;
    logic            r_out_stable;
    logic [EW-1:0]   r_out_total;

    logic            full;
    logic            out_ok;
    logic            finish;
    logic            is_stable;
    logic [CW-1:0]   cx;
    logic [CW-1:0]   cy;
    logic [IW-1:0]   cpos;
    logic            c_inr;
    logic            c_last;
    logic [CW:0]     dsum;
    logic [EW:0]     acc;

    assign cx     = r_cmd[CW-1:0];
    assign cy     = r_cmd[2*CW-1:CW];
    assign cpos   = r_cmd[2*CW+IW-1:2*CW];
    assign c_inr  = r_cmd[2*CW+IW];
    assign c_last = r_cmd[2*CW+IW+1];

    assign full      = (r_nfill == FW'(HISTORY_FRAMES));
    assign out_ok    = !c_last || !r_out_vld || i_m_tready;
    assign finish    = (r_state == csd_pkg::BK_DONE) && out_ok;
    assign is_stable = full && (r_sum < r_thresh);
    assign dsum      = {1'b0, abs_diff(cx, r_rdata[CW-1:0])}
                     + {1'b0, abs_diff(cy, r_rdata[2*CW-1:CW])};
    assign acc       = {1'b0, r_sum} + (EW+1)'(dsum);

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(32-EW-1){1'b0}}, r_out_total, r_out_stable};

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            csd_pkg::BK_IDLE: begin
                if (i_cmd_vld) begin
                    o_pop   = 1'b1;
                    n_state = (full && i_cmd[2*CW+IW]) ? csd_pkg::BK_RUN : csd_pkg::BK_DONE;
                end
            end
            csd_pkg::BK_RUN: begin
                if (r_step == SW'(HISTORY_FRAMES - 1)) begin
                    n_state = csd_pkg::BK_FLUSH;
                end
            end
            csd_pkg::BK_FLUSH: begin
                n_state = csd_pkg::BK_DONE;
            end
            csd_pkg::BK_DONE: begin
                if (out_ok) begin
                    n_state = csd_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = csd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csd_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == csd_pkg::BK_IDLE) begin
            r_step  <= '0;
            r_raddr <= AW'(i_cmd[2*CW+IW-1:2*CW]);
        end else if (r_state == csd_pkg::BK_RUN) begin
            r_step  <= r_step + 1'b1;
            r_raddr <= r_raddr + AW'(MAX_CORNERS);
        end
        r_rd_skip <= (r_step == r_slot);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == csd_pkg::BK_RUN) begin
            r_rdata <= r_mem[r_raddr];
        end
        if (finish && c_inr) begin
            r_mem[r_base + AW'(cpos)] <= {cy, cx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld     <= 1'b0;
            r_sum        <= '0;
            r_thresh     <= csd_pkg::CSD_THRESH_RESET;
            r_nfill      <= '0;
            r_slot       <= '0;
            r_base       <= '0;
            r_out_vld    <= 1'b0;
            r_out_stable <= 1'b0;
            r_out_total  <= '0;
        end else begin
            r_rd_vld <= (r_state == csd_pkg::BK_RUN);
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (finish && c_last) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (r_rd_vld && !r_rd_skip) begin
                r_sum <= acc[EW] ? {EW{1'b1}} : acc[EW-1:0];
            end
            if (finish && c_last) begin
                r_out_stable <= is_stable;
                r_out_total  <= full ? r_sum : '0;
                r_sum        <= '0;
                if (is_stable) begin
                    r_nfill <= '0;
                    r_slot  <= '0;
                    r_base  <= '0;
                end else begin
                    if (!full) begin
                        r_nfill <= r_nfill + 1'b1;
                    end
                    if (r_slot == SW'(HISTORY_FRAMES - 1)) begin
                        r_slot <= '0;
                        r_base <= '0;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                        r_base <= r_base + AW'(MAX_CORNERS);
                    end
                end
            end
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfill <= FW'(HISTORY_FRAMES))
        else $error("Stored frame count exceeds the history depth.");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SW'(HISTORY_FRAMES - 1))
        else $error("History slot index out of range.");

    a_acc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> full)
        else $error("Motion accumulated while the history is not full.");

    a_stable_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && c_last && is_stable) |=> (r_nfill == '0 && r_slot == '0 && r_out_stable))
        else $error("Stable frame did not clear the history.");
`endif

endmodule

// ===== src/corner_set_stability_detector_unit.sv =====
// Corner set stability detector: top level joining the front, queue and back parts.
//
// Corners enter on the slave stream, one per transfer: tdata carries the column in
// bits 15:0 and the row in bits 31:16, both unsigned with four fraction bits, and
// tlast marks the final corner of a frame. Each frame end yields one transfer on the
// master stream with the stable flag in bit 0 and the summed motion in bits 27:1.
// The user writes the error threshold through the configuration port only while idle;
// the block itself does not enforce this. A corner with a full history and a position
// below MAX_CORNERS passes the idle, run, flush and done states of the back part, with
// one store read per stored frame in the run state; any other corner goes from idle
// straight to done. A two-entry queue lets the slave side keep accepting while the
// back part works, and the result register lets a new frame proceed while the previous
// result waits. With an idle back part, a frame result is registered from the done
// state of its last corner. When the receiver stalls, the back part halts at the next
// frame end until the result register frees, and the queue then fills and holds tready
// low. Reset empties the history and the queue and restores the default threshold;
// the corner store needs no clearing pass.
module corner_set_stability_detector_unit #(
    parameter int HISTORY_FRAMES = csd_pkg::CSD_HISTORY_FRAMES,
    parameter int MAX_CORNERS    = csd_pkg::CSD_MAX_CORNERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // corner_x [15:0], corner_y [31:16]
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // stable [0], total_error [27:1], zero [31:28]
    input  logic        i_cfg_we,
    input  logic [csd_pkg::CSD_ERR_W-1:0] i_cfg_wdata
);
    localparam int DW = 2 * csd_pkg::CSD_COORD_W + $clog2(MAX_CORNERS) + 2;

    logic          push;
    logic [DW-1:0] push_cmd;
    logic          q_full;
    logic          q_empty;
    logic          pop;
    logic [DW-1:0] pop_cmd;

    csd_front #(
        .MAX_CORNERS(MAX_CORNERS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_full     (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    csd_queue #(
        .W    (DW),
        .DEPTH(csd_pkg::CSD_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    csd_back #(
        .HISTORY_FRAMES(HISTORY_FRAMES),
        .MAX_CORNERS   (MAX_CORNERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (!q_empty),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the corner set stability detector stream interface.
module tb;

    localparam int HF          = csd_pkg::CSD_HISTORY_FRAMES;
    localparam int MC          = csd_pkg::CSD_MAX_CORNERS;
    localparam int ERR_W       = csd_pkg::CSD_ERR_W;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_ITEMS = 200;
    localparam int PHASES      = 7;
    localparam logic [ERR_W-1:0] ERR_MAX = '1;

    typedef struct packed {
        logic             stable;
        logic [ERR_W-1:0] total;
    } t_frame_result;

    typedef struct packed {
        logic [15:0]   x;
        logic [15:0]   y;
        logic          last;
        logic          typed;
        t_frame_result want;
    } t_corner_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [31:0]      i_s_tdata;
    logic             i_s_tlast;
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [31:0]      o_m_tdata;
    logic             i_cfg_we;
    logic [ERR_W-1:0] i_cfg_wdata;

    logic [31:0]      corner_hist [HF][MC];
    int               written_len [HF];
    int               frames_stored;
    int               write_slot;
    int               corner_pos;
    logic [ERR_W-1:0] motion_sum;
    logic [ERR_W-1:0] threshold;
    t_frame_result    pending_results [$];
    int               mismatches;
    bit               hold_request;
    bit               sender_burst;
    logic [15:0]      base_x [MC];
    logic [15:0]      base_y [MC];

    // Fill frames after reset always report not stable with zero motion.
    t_corner_row directed_rows [22] = '{
        '{16'h0000, 16'h0000, 1'b0, 1'b0, 28'd0},
        '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 28'd0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 28'd0},
        '{16'h0000, 16'hFFFF, 1'b1, 1'b1, 28'd0},
        '{16'h8000, 16'h7FFF, 1'b0, 1'b0, 28'd0},
        '{16'h7FFF, 16'h8000, 1'b1, 1'b1, 28'd0},
        '{16'h5555, 16'hAAAA, 1'b0, 1'b0, 28'd0},
        '{16'hAAAA, 16'h5555, 1'b1, 1'b1, 28'd0},
        '{16'h1230, 16'h4560, 1'b0, 1'b0, 28'd0},
        '{16'h1231, 16'h4561, 1'b1, 1'b1, 28'd0},
        '{16'h1232, 16'h4560, 1'b0, 1'b0, 28'd0},
        '{16'h1230, 16'h4562, 1'b1, 1'b1, 28'd0},
        '{16'h1231, 16'h4561, 1'b0, 1'b0, 28'd0},
        '{16'h1233, 16'h4563, 1'b1, 1'b1, 28'd0},
        '{16'h1230, 16'h4561, 1'b0, 1'b0, 28'd0},
        '{16'h1232, 16'h4560, 1'b1, 1'b1, 28'd0},
        '{16'h1231, 16'h4562, 1'b0, 1'b0, 28'd0},
        '{16'h1231, 16'h4561, 1'b1, 1'b1, 28'd0},
        '{16'h1230, 16'h4560, 1'b0, 1'b0, 28'd0},
        '{16'h1232, 16'h4562, 1'b1, 1'b1, 28'd0},
        '{16'h1231, 16'h4561, 1'b0, 1'b0, 28'd0},
        '{16'h1232, 16'h4562, 1'b1, 1'b0, 28'd0}
    };

    corner_set_stability_detector_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] coord_gap(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int sender_gap();
        int r;
        if (sender_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic expect_result(input t_frame_result r);
        pending_results = {pending_results, r};
    endtask

    task automatic track_corner(input logic [15:0] x, input logic [15:0] y, input logic last,
                                output bit has_res, output t_frame_result res);
        bit     full;
        int     slot;
        longint acc;
        full = frames_stored >= HF;
        slot = full ? write_slot : frames_stored;
        if (slot >= HF) slot = 0;
        has_res = 1'b0;
        res     = '0;
        if (corner_pos < MC) begin
            if (full) begin
                acc = motion_sum;
                for (int s = 0; s < HF; s++) begin
                    if (s != slot) begin
                        acc += coord_gap(x, corner_hist[s][corner_pos][15:0]);
                        acc += coord_gap(y, corner_hist[s][corner_pos][31:16]);
                    end
                end
                motion_sum = (acc > ERR_MAX) ? ERR_MAX : acc[ERR_W-1:0];
            end
            corner_hist[slot][corner_pos] = {y, x};
            if (corner_pos + 1 > written_len[slot]) written_len[slot] = corner_pos + 1;
            corner_pos++;
        end
        if (last) begin
            has_res = 1'b1;
            if (!full) begin
                frames_stored++;
            end else begin
                res.total  = motion_sum;
                res.stable = motion_sum < threshold;
                if (res.stable) begin
                    frames_stored = 0;
                    write_slot    = 0;
                end else begin
                    write_slot = (slot + 1) % HF;
                end
            end
            corner_pos = 0;
            motion_sum = '0;
        end
    endtask

    task automatic offer_corner(input logic [15:0] x, input logic [15:0] y, input logic last,
                                output bit has_res, output t_frame_result res);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {y, x};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        track_corner(x, y, last, has_res, res);
    endtask

    task automatic set_threshold(input logic [ERR_W-1:0] value);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        threshold   = value;
    endtask

    task automatic new_target();
        for (int p = 0; p < MC; p++) begin
            base_x[p] = 16'($urandom_range(0, 65532));
            base_y[p] = 16'($urandom_range(0, 65532));
        end
    endtask

    initial begin
        int               n;
        int               limit;
        int               slot;
        int               amp;
        int               phase_items;
        bit               full;
        bit               noisy;
        bit               has_res;
        t_frame_result    res;
        logic [15:0]      x;
        logic [15:0]      y;
        logic [ERR_W-1:0] thr;

        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tlast   <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        for (int s = 0; s < HF; s++) begin
            written_len[s] = 0;
            for (int p = 0; p < MC; p++) corner_hist[s][p] = '0;
        end
        frames_stored = 0;
        write_slot    = 0;
        corner_pos    = 0;
        motion_sum    = '0;
        threshold     = csd_pkg::CSD_THRESH_RESET;
        mismatches    = 0;
        hold_request  = 1'b0;
        sender_burst  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            offer_corner(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                         has_res, res);
            if (has_res) begin
                expect_result(directed_rows[i].typed ? directed_rows[i].want : res);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                case (p)
                    1:       thr = '0;
                    2:       thr = '1;
                    3:       thr = 27'd500;
                    4:       thr = 27'd83884800;
                    5:       thr = ERR_W'($urandom_range(0, 20000));
                    default: thr = 27'd3000;
                endcase
                set_threshold(thr);
            end
            sender_burst = (p % 3 == 2);
            amp = $urandom_range(0, 3);
            new_target();
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                full = frames_stored >= HF;
                slot = full ? write_slot : frames_stored;
                if (slot >= HF) slot = 0;
                limit = MC;
                if (full) begin
                    for (int s = 0; s < HF; s++) begin
                        if (s != slot && written_len[s] < limit) limit = written_len[s];
                    end
                end
                if ($urandom_range(0, full ? 11 : 5) == 0) begin
                    n = (limit == MC) ? $urandom_range(MC - 6, MC + 6) : limit;
                end else begin
                    n = $urandom_range(1, (limit < 6) ? limit : 6);
                end
                noisy = ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 24) == 0) new_target();
                for (int c = 0; c < n; c++) begin
                    if (noisy) begin
                        x = 16'($urandom);
                        y = 16'($urandom);
                    end else begin
                        x = base_x[c % MC] + 16'($urandom_range(0, amp));
                        y = base_y[c % MC] + 16'($urandom_range(0, amp));
                    end
                    offer_corner(x, y, c == n - 1, has_res, res);
                    if (has_res) expect_result(res);
                    phase_items++;
                    if (p == 2 && phase_items >= 40) hold_request = 1'b1;
                end
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // The receiver stalls at random and once holds off long enough to back up the input.
    initial begin
        int r;
        bit long_done;
        long_done  = 1'b0;
        i_m_tready <= 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (!long_done && hold_request) begin
                long_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (r < 45) begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else if (r < 52) begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge i_clk);
            end else if (r < 92) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer with none expected, tdata %h", $time, o_m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[0] !== want.stable) begin
                    mismatches++;
                    $display("%0t: stable expected %b actual %b",
                             $time, want.stable, o_m_tdata[0]);
                end
                if (o_m_tdata[27:1] !== want.total) begin
                    mismatches++;
                    $display("%0t: total_error expected %0d actual %0d",
                             $time, want.total, o_m_tdata[27:1]);
                end
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("tb NOT OK");
        $finish;
    end

endmodule
